// ----- hdl/mi3_pkg.sv -----
// Package for the 3x3 matrix inverse: element widths, derived datapath widths,
// item types for both channels and the queue entry between front and back.
// No dependencies.
package mi3_pkg;

  localparam int EW = 32;
  localparam int FB = 16;
  localparam int CW = 2 * EW + 1;
  localparam int DW = 3 * EW + 3;
  localparam int QB = EW + 1;
  localparam int SW = DW + QB + 2;
  localparam int QD = 4;
  localparam int QAW = $clog2(QD);

  localparam int PA [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
  localparam int PB [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

  localparam logic [EW-1:0] ELEM_MAX = (EW'(1) << (EW - 1)) - EW'(1);
  localparam logic [EW-1:0] ELEM_MIN = EW'(1) << (EW - 1);
  localparam logic [EW-1:0] UNITY = (FB < EW - 1) ? (EW'(1) << FB) : ELEM_MAX;
  localparam logic [QB:0] LIM = (QB + 1)'(1) << (EW - 1);

  typedef struct packed {
    logic signed [EW-1:0] a00;
    logic signed [EW-1:0] a01;
    logic signed [EW-1:0] a02;
    logic signed [EW-1:0] a10;
    logic signed [EW-1:0] a11;
    logic signed [EW-1:0] a12;
    logic signed [EW-1:0] a20;
    logic signed [EW-1:0] a21;
    logic signed [EW-1:0] a22;
  } mat_t;

  typedef struct packed {
    logic signed [EW-1:0] inv00;
    logic signed [EW-1:0] inv01;
    logic signed [EW-1:0] inv02;
    logic signed [EW-1:0] inv10;
    logic signed [EW-1:0] inv11;
    logic signed [EW-1:0] inv12;
    logic signed [EW-1:0] inv20;
    logic signed [EW-1:0] inv21;
    logic signed [EW-1:0] inv22;
    logic                 singular;
  } res_t;

  typedef struct packed {
    logic [8:0][CW-1:0] cmag;
    logic [8:0]         cneg;
    logic [DW-1:0]      dmag;
    logic               dneg;
    logic               sing;
  } job_t;

endpackage

// ----- hdl/mi3_front.sv -----
// Front part: registers the matrix, forms cofactors and determinant exactly,
// and classifies each item into magnitudes, signs and a singular flag.
// Depends on mi3_pkg.
module mi3_front
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic mat_valid,
  output logic mat_stall,
  input  mat_t mat,
  input  logic full,
  output logic push,
  output job_t job
);

  logic en;
  logic v1, v2, v3, v4, v5;
  logic [8:0][EW-1:0] m1;
  logic signed [2*EW-1:0] p2 [18];
  logic signed [EW-1:0] row2 [3];
  logic signed [EW-1:0] row3 [3];
  logic signed [CW-1:0] c3 [9];
  logic signed [CW-1:0] c4 [9];
  logic signed [CW-1:0] c5 [9];
  logic signed [2*EW:0] pl4 [3];
  logic signed [2*EW:0] ph4 [3];
  logic signed [DW-1:0] det5;

  assign en = !full;
  assign mat_stall = full;
  assign push = v5 && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= mat_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1[0] <= mat.a00;
      m1[1] <= mat.a01;
      m1[2] <= mat.a02;
      m1[3] <= mat.a10;
      m1[4] <= mat.a11;
      m1[5] <= mat.a12;
      m1[6] <= mat.a20;
      m1[7] <= mat.a21;
      m1[8] <= mat.a22;
      for (int j = 0; j < 18; j++) begin
        p2[j] <= $signed(m1[PA[j]]) * $signed(m1[PB[j]]);
      end
      for (int j = 0; j < 3; j++) begin
        row2[j] <= $signed(m1[j]);
        row3[j] <= row2[j];
      end
      for (int i = 0; i < 9; i++) begin
        c3[i] <= CW'(p2[2*i]) - CW'(p2[2*i+1]);
        c4[i] <= c3[i];
        c5[i] <= c4[i];
      end
      for (int j = 0; j < 3; j++) begin
        pl4[j] <= row3[j] * $signed({1'b0, c3[3*j][EW-1:0]});
        ph4[j] <= row3[j] * $signed(c3[3*j][CW-1:EW]);
      end
      det5 <= (DW'(ph4[0]) <<< EW) + DW'(pl4[0])
            + (DW'(ph4[1]) <<< EW) + DW'(pl4[1])
            + (DW'(ph4[2]) <<< EW) + DW'(pl4[2]);
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      job.cmag[i] = c5[i][CW-1] ? CW'(-c5[i]) : CW'(c5[i]);
      job.cneg[i] = c5[i][CW-1];
    end
    job.dmag = det5[DW-1] ? DW'(-det5) : DW'(det5);
    job.dneg = det5[DW-1];
    job.sing = (det5 == '0);
  end

endmodule

// ----- hdl/mi3_queue.sv -----
// Short queue between the front and back parts of the matrix inverse.
// Depends on mi3_pkg.
module mi3_queue
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output job_t rdata
);

  job_t mem [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0] count;

  assign full = (count == (QAW + 1)'(QD));
  assign nonempty = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/mi3_back.sv -----
// Back part: pipelined restoring division of the nine cofactors by the
// determinant, one quotient bit per stage, then rounding and saturation;
// a singular item gives the identity matrix. Depends on mi3_pkg.
module mi3_back
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic nonempty,
  input  job_t job,
  output logic pop,
  input  logic inv_stall,
  output logic inv_valid,
  output res_t inv
);

  logic en;
  logic vs [QB+2];
  logic sg [QB+2];
  logic [8:0] ng [QB+2];
  logic [SW-1:0] dds [QB+1];
  logic [SW-1:0] rr [QB+1][9];
  logic [QB:0] qq [QB+2][9];
  logic [8:0][EW-1:0] el;
  res_t res_next;

  assign en = !(inv_valid && inv_stall);
  assign pop = en && nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dds[0] <= SW'(job.dmag) << 1;
      sg[0] <= job.sing;
      for (int e = 0; e < 9; e++) begin
        rr[0][e] <= (SW'(job.cmag[e]) << (2 * FB + 1)) + SW'(job.dmag);
        qq[0][e] <= '0;
        ng[0][e] <= job.cneg[e] ^ job.dneg;
      end
    end
  end

  for (genvar s = 0; s <= QB; s++) begin : g_div
    localparam int K = QB - s;
    logic [SW-1:0] dsh;
    logic [8:0] ge;

    always_comb begin
      dsh = dds[s] << K;
      for (int e = 0; e < 9; e++) begin
        ge[e] = (rr[s][e] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[s+1] <= 1'b0;
      end else if (en) begin
        vs[s+1] <= vs[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sg[s+1] <= sg[s];
        ng[s+1] <= ng[s];
        for (int e = 0; e < 9; e++) begin
          qq[s+1][e] <= {qq[s][e][QB-1:0], ge[e]};
        end
      end
    end

    if (s < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dds[s+1] <= dds[s];
          for (int e = 0; e < 9; e++) begin
            rr[s+1][e] <= ge[e] ? rr[s][e] - dsh : rr[s][e];
          end
        end
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      if (sg[QB+1]) begin
        el[e] = (e % 4 == 0) ? UNITY : '0;
      end else if (!ng[QB+1][e] && qq[QB+1][e] >= LIM) begin
        el[e] = ELEM_MAX;
      end else if (ng[QB+1][e] && qq[QB+1][e] > LIM) begin
        el[e] = ELEM_MIN;
      end else if (ng[QB+1][e]) begin
        el[e] = EW'(-qq[QB+1][e]);
      end else begin
        el[e] = EW'(qq[QB+1][e]);
      end
    end
    res_next.inv00 = el[0];
    res_next.inv01 = el[1];
    res_next.inv02 = el[2];
    res_next.inv10 = el[3];
    res_next.inv11 = el[4];
    res_next.inv12 = el[5];
    res_next.inv20 = el[6];
    res_next.inv21 = el[7];
    res_next.inv22 = el[8];
    res_next.singular = sg[QB+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid <= 1'b0;
    end else if (en) begin
      inv_valid <= vs[QB+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv <= res_next;
    end
  end

endmodule

// ----- hdl/matrix3_inverse.sv -----
// Top level of the 3x3 matrix inverse: front, queue and back parts.
// Depends on mi3_pkg, mi3_front, mi3_queue and mi3_back.
//
//   Channel  Handshake            Payload
//   input    mat_valid/mat_stall  mat (mat_t, nine Q16.16 elements)
//   output   inv_valid/inv_stall  inv (res_t, nine Q16.16 elements, singular)
//
// One item is accepted per cycle while the queue is not full. Without stalls
// an item passes five front stages, one queue write, one divider load stage,
// 34 quotient-bit stages and the output register. The divider dominates.
// Reset clears all valid bits and the queue pointers.
// An output stall holds the back part; the front keeps accepting until the
// four-entry queue is full.
module matrix3_inverse
  import mi3_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic mat_valid,
  output logic mat_stall,
  input  mat_t mat,
  output logic inv_valid,
  input  logic inv_stall,
  output res_t inv
);

  logic full;
  logic push;
  logic pop;
  logic nonempty;
  job_t wjob;
  job_t rjob;

  mi3_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .mat       (mat),
    .full      (full),
    .push      (push),
    .job       (wjob)
  );

  mi3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (wjob),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .rdata    (rjob)
  );

  mi3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .job       (rjob),
    .pop       (pop),
    .inv_stall (inv_stall),
    .inv_valid (inv_valid),
    .inv       (inv)
  );

endmodule
